[sv/phef_pkg.sv]
// Shared types and constants of the peak-hold envelope follower.
// Used by the channel interfaces, the controller, the datapath and the top level.
package phef_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PeakW   = 17;
  localparam int unsigned SinceW  = 25;
  localparam int unsigned GainW   = 16;
  localparam int unsigned HoldW   = 24;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // Register map of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD = 2'd2;

  localparam logic [GainW-1:0]   GAIN_RST   = 16'd4096;
  localparam logic [HoldW-1:0]   HOLD_RST   = 24'd14;
  localparam logic [PeriodW-1:0] PERIOD_RST = 32'd97391;

  localparam logic [SinceW-1:0] SINCE_MAX = '1;

  // Datapath word widths.
  localparam int unsigned AW    = 41;  // |diff| * since_update, at most 2^40
  localparam int unsigned SMagW = 57;  // slope magnitude, Q.16
  localparam int unsigned SumW  = 59;  // signed held*2^16 + slope
  localparam int unsigned MagW  = 45;  // clamped |sum|, at most 2^44

  localparam logic [MagW-1:0] SUM_CLAMP = {1'b1, {(MagW-1){1'b0}}};

  localparam logic signed [SampleW-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] OUT_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_CLAMP,
    ST_OUT
  } phef_state_e;

  // Step strobes from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic do_a;
    logic do_hi;
    logic do_lo;
    logic do_clamp;
    logic do_out;
  } phef_cmd_t;

endpackage

[sv/phef_if.sv]
// Valid/ready channel interfaces for sample requests and envelope results.
// Depends on phef_pkg for the field widths.
interface phef_in_if import phef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface phef_out_if import phef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] envelope_out;

  modport source (output valid, output envelope_out, input ready);
  modport sink (input valid, input envelope_out, output ready);
endinterface

[sv/peak_hold_envelope_follower_core.sv]
// Peak-hold envelope follower, top level.
// Depends on phef_pkg, phef_in_if/phef_out_if, phef_ctrl and phef_dp.
//
// Usage:
//   in_i  carries one signed 16-bit audio sample per request (valid/ready).
//   out_o returns one signed 16-bit envelope sample per request, in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write gain (0), hold_samples (1) and
//   sample_period (2); other indexes are dropped. Write only while idle.
// Sequence:
//   A request is taken in the idle state. Its result reaches the output
//   register through these steps: one for |diff|*count, two for the
//   41x32 period multiply split in 41x16 halves, one for sum and clamp,
//   one for the gain multiply and saturation. No new request is taken
//   before the last step; one request at a time runs the shared chain.
// Stall:
//   The output register lets the next request start while a result waits.
//   If the receiver still holds off when the next result is ready, the
//   sequencer waits in its last step and accepts nothing until it drains.
// Reset:
//   Registers return to gain 1.0, hold 14 and period 97391; peak, prior
//   peak and elapsed count clear to zero; no result is pending.
module peak_hold_envelope_follower_core import phef_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  phef_in_if.sink            in_i,
  phef_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  phef_cmd_t cmd;

  // Sequence each request through the datapath steps.
  phef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Hold the configuration and peak state, and run the arithmetic.
  phef_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sample_i   (in_i.sample_in),
    .env_o      (out_o.envelope_out)
  );

  // Only one datapath step runs in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.do_a, cmd.do_hi, cmd.do_lo, cmd.do_clamp, cmd.do_out}))
    else $error("more than one datapath step active");

  // Accepting a request makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while a request is in progress");

  // Once accepted, a request runs through the multiply steps to the clamp
  // step; no receiver stall can come between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> ##4 cmd.do_clamp)
    else $error("datapath sequence out of order");

  // A finished result is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_out |=> out_o.valid)
    else $error("result not presented after output step");

endmodule

[sv/phef_ctrl.sv]
// Sequencer of the envelope follower: walks one request through the datapath steps.
// Depends on phef_pkg; drives the datapath through a phef_cmd_t strobe bundle.
module phef_ctrl import phef_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output phef_cmd_t cmd_o
);

  phef_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_A;
      ST_MUL_A:  state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL_A:  cmd_o.do_a     = 1'b1;
      ST_MUL_HI: cmd_o.do_hi    = 1'b1;
      ST_MUL_LO: cmd_o.do_lo    = 1'b1;
      ST_CLAMP:  cmd_o.do_clamp = 1'b1;
      ST_OUT:    cmd_o.do_out   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.do_out) out_valid_d = 1'b1;
    else if (out_ready_i)      out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/phef_dp.sv]
// Datapath of the envelope follower: configuration, peak state and the
// multiply chain. Depends on phef_pkg; stepped by phef_cmd_t strobes.
module phef_dp import phef_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  phef_cmd_t                 cmd_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic signed [SampleW-1:0] env_o
);

  logic [GainW-1:0]   gain_q;
  logic [HoldW-1:0]   hold_q;
  logic [PeriodW-1:0] period_q;

  logic [PeakW-1:0]  held_q, prior_q;
  logic [SinceW-1:0] since_q;

  logic              dneg_q;
  logic [AW-1:0]     a_q;
  logic [SMagW-1:0]  phi_q, smag_q;
  logic              neg_q;
  logic [MagW-1:0]   mag_q;
  logic signed [SampleW-1:0] env_q;

  // Peak update
  logic [SinceW-1:0] since_inc;
  logic [PeakW-1:0]  sample_ext, sample_abs;
  logic              renew;

  assign since_inc  = (since_q == SINCE_MAX) ? since_q : since_q + 1'b1;
  assign sample_ext = {sample_i[SampleW-1], sample_i};
  assign sample_abs = sample_i[SampleW-1] ? (~sample_ext + 1'b1) : sample_ext;
  // Compare against the signed sample: a negative sample never renews by level.
  assign renew = (since_inc > {1'b0, hold_q}) ||
                 ($signed({1'b0, held_q}) <= $signed({{2{sample_i[SampleW-1]}}, sample_i}));

  // Slope magnitude
  logic [PeakW:0]     diff;
  logic [PeakW-1:0]   dmag;
  logic [PeakW+SinceW-1:0] a_full;
  logic [AW+15:0]     plo_full;

  assign diff     = {1'b0, held_q} - {1'b0, prior_q};
  assign dmag     = diff[PeakW] ? PeakW'(-diff) : diff[PeakW-1:0];
  assign a_full   = dmag * since_q;
  assign plo_full = a_q * period_q[15:0];

  // Sum and clamp
  logic signed [SumW-1:0] held_s, smag_s, sum;
  logic [SumW-1:0]        sum_mag;

  assign held_s  = $signed(SumW'({held_q, 16'b0}));
  assign smag_s  = $signed(SumW'(smag_q));
  assign sum     = dneg_q ? (held_s - smag_s) : (held_s + smag_s);
  assign sum_mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);

  // Gain and saturation
  logic [MagW+GainW-1:0] prod;
  logic [MagW+GainW-29:0] r;
  logic signed [SampleW-1:0] env_d;

  assign prod = mag_q * gain_q;
  assign r    = prod[MagW+GainW-1:28];

  always_comb begin
    if (neg_q) begin
      env_d = (r > 33'd32768) ? OUT_MIN : SampleW'(-r);
    end else begin
      env_d = (r > 33'd32767) ? OUT_MAX : $signed(r[SampleW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      hold_q   <= HOLD_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN:   gain_q   <= cfg_data_i[GainW-1:0];
        CFG_HOLD:   hold_q   <= cfg_data_i[HoldW-1:0];
        CFG_PERIOD: period_q <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      prior_q <= '0;
      since_q <= '0;
    end else if (cmd_i.accept) begin
      if (renew) begin
        prior_q <= held_q;
        held_q  <= sample_abs;
        since_q <= '0;
      end else begin
        since_q <= since_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_a) begin
      a_q    <= a_full[AW-1:0];
      dneg_q <= diff[PeakW];
    end
    if (cmd_i.do_hi)    phi_q  <= SMagW'(a_q * period_q[31:16]);
    if (cmd_i.do_lo)    smag_q <= phi_q + SMagW'(plo_full[AW+15:16]);
    if (cmd_i.do_clamp) begin
      neg_q <= sum[SumW-1];
      mag_q <= (sum_mag > SumW'(SUM_CLAMP)) ? SUM_CLAMP : sum_mag[MagW-1:0];
    end
    if (cmd_i.do_out)   env_q  <= env_d;
  end

  assign env_o = env_q;

endmodule

[tb/sv/peak_hold_envelope_follower_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for peak_hold_envelope_follower_core.
// Depends on phef_pkg, phef_in_if/phef_out_if and the core itself.
module peak_hold_envelope_follower_core_test;
  import phef_pkg::*;

  // Index that the register map leaves unused; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam int CLK_HALF      = 10;
  localparam int IDLE_GAP      = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int PER_SETTING   = 110;      // random requests per register setting
  localparam int DECAY_HOLD    = 8500;     // longer than the decay run: no timeout
  localparam int DECAY_RUN     = 100;
  localparam int TAIL_RUN      = 50;
  localparam int LONG_STALL    = 400;
  localparam int STALL_AFTER   = 150;
  localparam int NUM_ROWS      = 26;

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One row of the directed table: a register write or a sample request,
  // with the envelope typed in where it is obvious.
  typedef struct packed {
    row_kind_e                 kind;
    logic [CfgIdxW-1:0]        idx;
    logic [CfgW-1:0]           data;
    logic signed [SampleW-1:0] sample;
    logic                      fixed;
    logic signed [SampleW-1:0] env;
  } row_t;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      fixed;
    logic signed [SampleW-1:0] env;
  } request_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  phef_in_if  in_ch ();
  phef_out_if out_ch ();

  peak_hold_envelope_follower_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register mirror and envelope state of the predictor.
  logic [GainW-1:0]   gain_reg;
  logic [HoldW-1:0]   hold_reg;
  logic [PeriodW-1:0] period_reg;
  logic [PeakW-1:0]   pk_held;
  logic [PeakW-1:0]   pk_prior;
  logic [SinceW-1:0]  pk_count;

  request_t                  sample_q[$];   // requests still to be offered
  logic signed [SampleW-1:0] envelope_q[$]; // envelopes still to arrive

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int requests_sent;
  int results_seen;
  int writes_done;
  int cycle_count;
  int stall_left;
  bit long_stall_done;

  // Directed table. Extremes, the signed peak test (a negative sample never
  // renews by level), renewal on an equal sample, renewal by timeout with the
  // most negative sample, gain truncation, zero gain, the unused index, and
  // the extreme hold and period settings.
  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd0,      1'b1, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd32767,  1'b1, OUT_MAX},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sh8000,   1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          -16'sd1,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd100,    1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd32767,  1'b1, OUT_MAX},
    '{ROW_WRITE,  CFG_HOLD,   32'd2,          16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd5,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          -16'sd5,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sh8000,   1'b1, OUT_MAX},
    '{ROW_WRITE,  CFG_GAIN,   32'd0,          16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd1234,   1'b1, 16'sd0},
    '{ROW_WRITE,  CFG_SPARE,  32'hFFFF_FFFF,  16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd7,      1'b1, 16'sd0},
    '{ROW_WRITE,  CFG_GAIN,   32'hFFFF_FFFF,  16'sd0,      1'b0, 16'sd0},
    '{ROW_WRITE,  CFG_HOLD,   32'd0,          16'sd0,      1'b0, 16'sd0},
    '{ROW_WRITE,  CFG_PERIOD, 32'hFFFF_FFFF,  16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd1,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sh8000,   1'b1, OUT_MAX},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd0,      1'b0, 16'sd0},
    '{ROW_WRITE,  CFG_PERIOD, 32'd0,          16'sd0,      1'b0, 16'sd0},
    '{ROW_WRITE,  CFG_HOLD,   32'hABFF_FFFF,  16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          16'sd20000,  1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          -16'sd3,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_GAIN,   32'd0,          -16'sd3,     1'b0, 16'sd0}
  };

  // Advance the envelope state by one sample and return the envelope it gives.
  function automatic logic signed [SampleW-1:0] advance_envelope(
      logic signed [SampleW-1:0] s);
    longint    diff;
    longint    slope;
    longint    total;
    longint    env;
    int        s_mag;
    bit [63:0] dmag;
    bit [63:0] a;
    bit [63:0] smag;
    bit [63:0] mag;
    bit [63:0] r;

    if (pk_count < SINCE_MAX) pk_count++;

    // Renew on timeout, or when the signed sample reaches the held magnitude.
    if (pk_count > hold_reg || int'(pk_held) <= int'(s)) begin
      s_mag    = (s < 0) ? -int'(s) : int'(s);
      pk_prior = pk_held;
      pk_held  = s_mag[PeakW-1:0];
      pk_count = '0;
    end

    // Slope term in Q.16: |diff| * count * period / 2^16, sign applied after.
    diff  = longint'(pk_held) - longint'(pk_prior);
    dmag  = (diff < 0) ? -diff : diff;
    a     = dmag * pk_count;
    smag  = a * period_reg[31:16] + ((a * period_reg[15:0]) >> 16);
    slope = (diff < 0) ? -longint'(smag) : longint'(smag);
    total = (longint'(pk_held) <<< 16) + slope;

    mag = (total < 0) ? -total : total;
    if (mag > (64'd1 << 44)) mag = 64'd1 << 44;
    r = (mag * gain_reg) >> 28;

    if (total < 0) begin
      if (r > 64'd32768) return OUT_MIN;
      env = -longint'(r);
      return env[SampleW-1:0];
    end
    if (r > 64'd32767) return OUT_MAX;
    return r[SampleW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      1, 2: v = $urandom_range(32767, 16384);
      3, 4, 5: v = int'($urandom_range(600)) - 300;
      6, 7: v = -int'($urandom_range(32768, 1));
      default: v = $urandom();
    endcase
    return v[SampleW-1:0];
  endfunction

  task automatic queue_sample(logic signed [SampleW-1:0] s);
    request_t req;
    req.sample = s;
    req.fixed  = 1'b0;
    req.env    = '0;
    sample_q.push_back(req);
  endtask

  // Queue note-like bursts: one loud onset, then a run of random samples
  // about as long as a hold under 40, else up to 40 long, so timeouts and decays both show up.
  task automatic queue_notes(int count);
    int left;
    int run;
    left = count;
    while (left > 0) begin
      if ($urandom_range(7) == 0) queue_sample(OUT_MIN);
      else queue_sample(SampleW'($urandom_range(32767, 8192)));
      left--;
      if (hold_reg < 40) run = int'(hold_reg) + $urandom_range(3);
      else run = $urandom_range(40);
      for (int i = 0; i < run && left > 0; i++) begin
        queue_sample(pick_sample());
        left--;
      end
    end
  endtask

  // Write one register; the mirror follows at the same edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_GAIN:   gain_reg = data[GainW-1:0];
      CFG_HOLD:   hold_reg = data[HoldW-1:0];
      CFG_PERIOD: period_reg = data;
      default: ;
    endcase
    writes_done++;
  endtask

  // Hold until every queued request is taken and every envelope is back.
  task automatic wait_idle();
    wait (sample_q.size() == 0 && envelope_q.size() == 0);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Request side: hold a request until it is taken, then predict its
  // envelope. Idle between requests at the current rate.
  always @(posedge clk_i) begin
    logic offer;
    logic waiting;
    request_t req;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req = sample_q.pop_front();
        if (req.fixed) begin
          void'(advance_envelope(req.sample));
          envelope_q.push_back(req.env);
        end else begin
          envelope_q.push_back(advance_envelope(req.sample));
        end
        requests_sent++;
      end
      waiting = in_ch.valid && !in_ch.ready;
      offer = sample_q.size() != 0 &&
              (waiting || $urandom_range(99) >= send_idle_pct);
      in_ch.valid <= offer;
      if (offer) in_ch.sample_in <= sample_q[0].sample;
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the core
  // fill up and push back on its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!long_stall_done && results_seen >= STALL_AFTER) begin
      long_stall_done <= 1'b1;
      stall_left      <= LONG_STALL;
      out_ch.ready    <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each envelope with the oldest prediction.
  always @(posedge clk_i) begin
    logic signed [SampleW-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (envelope_q.size() == 0) begin
        $error("envelope_out: no request pending, got %0d", out_ch.envelope_out);
        fail_count++;
      end else begin
        want = envelope_q.pop_front();
        if (out_ch.envelope_out !== want) begin
          $error("envelope_out: expected %0d, got %0d", want, out_ch.envelope_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles, %0d envelopes outstanding",
               cycle_count, envelope_q.size());
      $display("FAIL peak_hold_envelope_follower_core");
      $finish;
    end
  end

  initial begin
    int directed_count;

    directed_count  = 0;
    fail_count      = 0;
    requests_sent   = 0;
    results_seen    = 0;
    writes_done     = 0;
    cycle_count     = 0;
    stall_left      = 0;
    long_stall_done = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    gain_reg        = GAIN_RST;
    hold_reg        = HOLD_RST;
    period_reg      = PERIOD_RST;
    pk_held         = '0;
    pk_prior        = '0;
    pk_count        = '0;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_GAIN;
    cfg_data_i       = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    out_ch.ready     = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table, draining before each register write.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        sample_q.push_back('{directed_rows[i].sample, directed_rows[i].fixed,
                             directed_rows[i].env});
        directed_count++;
      end
    end

    // Random part: four idling modes, two register settings in each.
    for (int mode = 0; mode < 4; mode++) begin
      for (int set = 0; set < 2; set++) begin
        wait_idle();
        case (mode)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
          default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        case ($urandom_range(4))
          0: write_reg(CFG_GAIN, 32'd0);
          1: write_reg(CFG_GAIN, 32'h0000_FFFF);
          2: write_reg(CFG_GAIN, 32'(GAIN_RST));
          default: write_reg(CFG_GAIN, $urandom());
        endcase
        case ($urandom_range(5))
          0: write_reg(CFG_HOLD, 32'd0);
          1: write_reg(CFG_HOLD, 32'h00FF_FFFF);
          2: write_reg(CFG_HOLD, $urandom());
          default: write_reg(CFG_HOLD, $urandom_range(40));
        endcase
        case ($urandom_range(4))
          0: write_reg(CFG_PERIOD, 32'd0);
          1: write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
          2: write_reg(CFG_PERIOD, PERIOD_RST);
          default: write_reg(CFG_PERIOD, $urandom());
        endcase
        queue_notes(PER_SETTING);
      end
    end

    // Long decay: full-scale peak, drop to zero, then a run of negative
    // samples so the negative slope term grows with the count and drives
    // the sum below zero. Finish the run at zero gain.
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_GAIN, 32'd1);
    write_reg(CFG_HOLD, 32'd0);
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    queue_sample(OUT_MIN);
    queue_sample(16'sd0);
    wait_idle();
    write_reg(CFG_HOLD, DECAY_HOLD);
    for (int i = 0; i < DECAY_RUN; i++) queue_sample(SampleW'(-int'($urandom_range(32768, 1))));
    wait_idle();
    write_reg(CFG_GAIN, 32'd0);
    for (int i = 0; i < TAIL_RUN; i++) queue_sample(SampleW'(-int'($urandom_range(32768, 1))));

    wait (sample_q.size() == 0 && envelope_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples (%0d directed), checked %0d envelopes, %0d register writes,",
             requests_sent, directed_count, results_seen, writes_done);
    $display("across four idling modes, a long output hold-off and a long decay run.");
    if (fail_count == 0) begin
      $display("PASS peak_hold_envelope_follower_core");
    end else begin
      $display("FAIL peak_hold_envelope_follower_core");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/phef_pkg.sv
sv/phef_if.sv
sv/phef_ctrl.sv
sv/phef_dp.sv
sv/peak_hold_envelope_follower_core.sv
tb/sv/peak_hold_envelope_follower_core_test.sv
